// ===== src/elf_string_hash_bucket_assert.svh =====
// ----------------------------------------------------------------------------
// elf string hash bucket assertion macros
// shared concurrent assertion forms, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ELF_STRING_HASH_BUCKET_ASSERT_SVH
`define ELF_STRING_HASH_BUCKET_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EHB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define EHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EHB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define EHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/ehb_pkg.sv =====
// ----------------------------------------------------------------------------
// ehb_pkg
// types, constants and the hash step shared by the elf string hash bucket
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ehb_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned HASH_W   = 28;
    localparam int unsigned TSIZE_W  = 17;
    localparam int unsigned BUCKET_W = 16;
    localparam int unsigned STEP_CNT_W = $clog2(HASH_W);

    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RESET = 17'd1024;
    localparam logic [TSIZE_W-1:0] TABLE_SIZE_MAX   = 17'd65536;
    localparam logic [31:0]        TOP_NIBBLE_MASK  = 32'hF000_0000;
    localparam int unsigned        FOLD_SHIFT       = 24;
    localparam int unsigned        STEP_SHIFT       = 4;
    localparam logic [STEP_CNT_W-1:0] DIV_STEP_LAST = STEP_CNT_W'(HASH_W - 1);

    // one finished name waiting for its bucket
    typedef struct packed {
        logic [HASH_W-1:0]  full_hash;
        logic [TSIZE_W-1:0] divisor;
    } ehb_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } ehb_back_state_t;

    function automatic logic [HASH_W-1:0] elf_step(
        input logic [HASH_W-1:0] h,
        input logic [CHAR_W-1:0] c
    );
        logic [31:0] s;
        logic [31:0] top;
        logic [31:0] r;
        s   = (32'(h) << STEP_SHIFT) + 32'(c);
        top = s & TOP_NIBBLE_MASK;
        r   = (s ^ (top >> FOLD_SHIFT)) & ~top;
        return r[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/elf_string_hash_bucket.sv =====
// ----------------------------------------------------------------------------
// elf_string_hash_bucket
// streaming pjw/elf name hash with bucket select by modulo of the table size
// ----------------------------------------------------------------------------
// one byte word is taken per cycle while in_ready is high and folded into a
// 28-bit running hash in the front stage; the word with is_last set closes
// the name, and its final hash plus the clamped table size go into a job
// queue of QUEUE_DEPTH entries. the back stage works out the bucket with a
// bit-serial remainder, one hash bit per cycle (load, 28 steps, result state
// held until out_ready) before the next job is taken. names that outpace it
// run ahead into the queue, and in_ready drops once it is full. the user
// writes table_size over the cfg port only while idle, which the block does
// not enforce; it resets to 1024, clamps at 65536, zero gives bucket zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module elf_string_hash_bucket #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // byte words of the name
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ehb_pkg::CHAR_W-1:0]    character,
    input  wire logic                          is_last,
    // one result word per name
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ehb_pkg::BUCKET_W-1:0]       bucket,
    output logic [ehb_pkg::HASH_W-1:0]         full_hash,
    // table size register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ehb_pkg::TSIZE_W-1:0]   cfg_data
);

    logic [ehb_pkg::TSIZE_W-1:0] table_size_reg;
    logic [ehb_pkg::TSIZE_W-1:0] table_size_next;

    logic              push_valid;
    logic              push_ready;
    ehb_pkg::ehb_job_t push_job;
    logic              pop_valid;
    logic              pop_ready;
    ehb_pkg::ehb_job_t pop_job;

    // register writes are always accepted and land in the following cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= ehb_pkg::TABLE_SIZE_RESET;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    // front: per-byte hash step, classify last byte
    ehb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .is_last    (is_last),
        .table_size (table_size_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // decouples byte intake from the modulo
    ehb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // back: remainder and result register
    ehb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bucket    (bucket),
        .full_hash (full_hash)
    );

endmodule

`default_nettype wire

// ===== src/ehb_front.sv =====
// ----------------------------------------------------------------------------
// ehb_front
// running hash per byte, hands finished names to the job queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ehb_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ehb_pkg::CHAR_W-1:0]    character,
    input  wire logic                          is_last,
    input  wire logic [ehb_pkg::TSIZE_W-1:0]   table_size,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output ehb_pkg::ehb_job_t                  push_job
);

    logic [ehb_pkg::HASH_W-1:0]  running_hash_reg;
    logic [ehb_pkg::HASH_W-1:0]  running_hash_next;
    logic [ehb_pkg::HASH_W-1:0]  step_hash;
    logic [ehb_pkg::TSIZE_W-1:0] divisor;
    logic                        accept;

    assign in_ready = push_ready;
    assign accept   = in_valid & in_ready;
    assign step_hash = ehb_pkg::elf_step(running_hash_reg, character);

    // sizes above the max clamp to the max
    assign divisor = (table_size > ehb_pkg::TABLE_SIZE_MAX) ? ehb_pkg::TABLE_SIZE_MAX
                                                            : table_size;

    assign push_valid         = accept & is_last;
    assign push_job.full_hash = step_hash;
    assign push_job.divisor   = divisor;

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = is_last ? '0 : step_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ehb_queue.sv =====
// ----------------------------------------------------------------------------
// ehb_queue
// small job fifo between the hash front and the modulo back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "elf_string_hash_bucket_assert.svh"

module ehb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire ehb_pkg::ehb_job_t  push_job,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output ehb_pkg::ehb_job_t       pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ehb_pkg::ehb_job_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `EHB_ASSERT_IMPLIES(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_FULL, "queue overfilled")
    `EHB_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "push lost")

endmodule

`default_nettype wire

// ===== src/ehb_back.sv =====
// ----------------------------------------------------------------------------
// ehb_back
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "elf_string_hash_bucket_assert.svh"

module ehb_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_valid,
    output logic                                job_ready,
    input  wire ehb_pkg::ehb_job_t              job,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ehb_pkg::BUCKET_W-1:0]        bucket,
    output logic [ehb_pkg::HASH_W-1:0]          full_hash
);

    ehb_pkg::ehb_back_state_t          state_reg;
    ehb_pkg::ehb_back_state_t          state_next;
    logic [ehb_pkg::STEP_CNT_W-1:0]    count_reg;
    logic [ehb_pkg::STEP_CNT_W-1:0]    count_next;
    logic [ehb_pkg::TSIZE_W-1:0]       rem_reg;
    logic [ehb_pkg::TSIZE_W-1:0]       rem_next;
    logic [ehb_pkg::HASH_W-1:0]        dvd_reg;
    logic [ehb_pkg::HASH_W-1:0]        dvd_next;
    logic [ehb_pkg::TSIZE_W-1:0]       div_reg;
    logic [ehb_pkg::TSIZE_W-1:0]       div_next;
    logic [ehb_pkg::HASH_W-1:0]        hash_reg;
    logic [ehb_pkg::HASH_W-1:0]        hash_next;
    logic [ehb_pkg::TSIZE_W-1:0]       trial;

    // remainder stays below the divisor, so its top bit is free for the shift
    assign trial = {rem_reg[ehb_pkg::TSIZE_W-2:0], dvd_reg[ehb_pkg::HASH_W-1]};

    assign bucket    = rem_reg[ehb_pkg::BUCKET_W-1:0];
    assign full_hash = hash_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        div_next   = div_reg;
        hash_next  = hash_reg;
        job_ready  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ehb_pkg::BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    hash_next  = job.full_hash;
                    dvd_next   = job.full_hash;
                    div_next   = job.divisor;
                    rem_next   = '0;
                    count_next = ehb_pkg::DIV_STEP_LAST;
                    // zero table size gives bucket zero directly
                    state_next = (job.divisor == '0) ? ehb_pkg::BK_DONE : ehb_pkg::BK_RUN;
                end
            end
            ehb_pkg::BK_RUN:
            begin
                rem_next   = (trial >= div_reg) ? trial - div_reg : trial;
                dvd_next   = dvd_reg << 1;
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ehb_pkg::BK_DONE;
                end
            end
            ehb_pkg::BK_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ehb_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ehb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ehb_pkg::BK_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        div_reg  <= div_next;
        hash_reg <= hash_next;
    end

    `EHB_ASSERT_IMPLIES(a_rem_below_div, clk, rst_n, state_reg == ehb_pkg::BK_RUN, rem_reg < div_reg, "remainder not reduced")
    `EHB_ASSERT_NEXT(a_run_ends, clk, rst_n, state_reg == ehb_pkg::BK_RUN && count_reg == '0, state_reg == ehb_pkg::BK_DONE, "divide overran")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for elf_string_hash_bucket
// names are streamed one byte word at a time under random valid and ready
// gaps; a scoreboard class folds every accepted byte into its own pjw/elf
// hash, queues the expected bucket and hash for each closed name, and checks
// every result word in order. the table size register is rewritten between
// phases, covering zero, one, the clamp at 65536 and sizes above it
// ----------------------------------------------------------------------------

module testbench;

    localparam int unsigned HALF_PERIOD    = 5;
    localparam int unsigned RESET_CYCLES   = 9;
    // back stage holds up to three jobs, two in its queue and one in work
    localparam int unsigned SETTLE_CYCLES  = 120;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned RANDOM_ITEMS   = 1550;
    localparam int unsigned PHASE_ITEMS    = 120;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned FIXED_PHASES   = 10;
    // phase in which the result side holds off and the input backs up
    localparam int unsigned PRESSURE_PHASE = 2;

    // expected result word of one name
    typedef struct packed {
        logic [ehb_pkg::BUCKET_W-1:0] bucket;
        logic [ehb_pkg::HASH_W-1:0]   full_hash;
    } name_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the running hash and the table size
    // ------------------------------------------------------------------------
    class name_hash_board;
        logic [ehb_pkg::HASH_W-1:0]  running;
        logic [ehb_pkg::TSIZE_W-1:0] table_size;
        name_result_t                pending_names[$];
        int unsigned                 mismatches;

        function new();
            running    = '0;
            table_size = ehb_pkg::TABLE_SIZE_RESET;
            mismatches = 0;
        endfunction

        function void set_table_size(input logic [ehb_pkg::TSIZE_W-1:0] value);
            table_size = value;
        endfunction

        function int unsigned pending();
            return pending_names.size();
        endfunction

        // fold one accepted byte word; a last byte closes the name
        function void take_byte(input logic [ehb_pkg::CHAR_W-1:0] c, input logic last);
            logic [31:0]                 sum;
            logic [31:0]                 top;
            logic [ehb_pkg::TSIZE_W-1:0] divisor;
            name_result_t                result;
            // shift and add wrap at 32 bits
            sum = {running, 4'b0000} + {24'b0, c};
            top = sum & ehb_pkg::TOP_NIBBLE_MASK;
            sum = (sum ^ (top >> ehb_pkg::FOLD_SHIFT)) & ~top;
            if (!last)
            begin
                running = sum[ehb_pkg::HASH_W-1:0];
                return;
            end
            running = '0;
            divisor = (table_size > ehb_pkg::TABLE_SIZE_MAX) ? ehb_pkg::TABLE_SIZE_MAX
                                                             : table_size;
            result.full_hash = sum[ehb_pkg::HASH_W-1:0];
            if (divisor == '0)
                result.bucket = '0;
            else
                result.bucket = ehb_pkg::BUCKET_W'(32'(sum[ehb_pkg::HASH_W-1:0])
                                                   % 32'(divisor));
            pending_names.push_back(result);
        endfunction

        // compare one accepted result word with the oldest name
        function void check_result(
            input logic [ehb_pkg::BUCKET_W-1:0] bucket,
            input logic [ehb_pkg::HASH_W-1:0]   full_hash
        );
            name_result_t want;
            if (pending_names.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: bucket %0d hash %07h",
                             bucket, full_hash);
                return;
            end
            want = pending_names.pop_front();
            if (want.bucket !== bucket || want.full_hash !== full_hash)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("hash check failed: bucket %0d/%0d hash %07h/%07h (exp/got)",
                             want.bucket, bucket, want.full_hash, full_hash);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_ready;
    logic [ehb_pkg::CHAR_W-1:0]   character  = '0;
    logic                         is_last    = 1'b0;
    logic                         out_valid;
    logic                         out_ready  = 1'b0;
    logic [ehb_pkg::BUCKET_W-1:0] bucket;
    logic [ehb_pkg::HASH_W-1:0]   full_hash;
    logic                         cfg_valid  = 1'b0;
    logic                         cfg_ready;
    logic [ehb_pkg::TSIZE_W-1:0]  cfg_data   = '0;

    name_hash_board hash_board = new();

    // sender pacing: runs of quiet (no gap) or busy words
    int unsigned tx_run_left = 0;
    logic        tx_quiet    = 1'b0;
    logic        tx_no_gaps  = 1'b0;
    // asks the result side for one long hold-off
    logic        hold_output = 1'b0;
    int unsigned idle_cycles = 0;

    always #(HALF_PERIOD) clk = ~clk;

    elf_string_hash_bucket u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .character (character),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bucket    (bucket),
        .full_hash (full_hash),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // monitor: every handshake is seen with the values from before the edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                hash_board.set_table_size(cfg_data);
            if (in_valid && in_ready)
                hash_board.take_byte(character, is_last);
            if (out_valid && out_ready)
                hash_board.check_result(bucket, full_hash);
        end
    end

    // watchdog: too long with no word moving on any channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("elf_string_hash_bucket: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, quiet stretches and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned run_left;
        logic        quiet;
        run_left = 0;
        quiet    = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                quiet    = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(1, 24);
            end
            run_left--;
            if (hold_output)
            begin
                // block keeps taking bytes until its job queue is full
                stall       = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------

    // offer one byte word; returns at the edge where it is taken
    task automatic send_char(input logic [ehb_pkg::CHAR_W-1:0] c, input logic last);
        int unsigned gap;
        if (tx_run_left == 0)
        begin
            tx_quiet    = ($urandom_range(0, 3) == 0);
            tx_run_left = $urandom_range(1, 24);
        end
        tx_run_left--;
        gap = (tx_quiet || tx_no_gaps) ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        is_last   <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // random name; some use only low bytes so the hash climbs toward the carry
    task automatic send_name(input int unsigned len);
        logic        low_bytes;
        logic [7:0]  c;
        low_bytes = ($urandom_range(0, 7) == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            c = low_bytes ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            send_char(c, i == len - 1);
        end
    endtask

    // only while idle: every result in, then room for the back stage to drain
    task automatic write_table_size(input logic [ehb_pkg::TSIZE_W-1:0] value);
        while (hash_board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ehb_pkg::TSIZE_W-1:0] fixed_sizes [FIXED_PHASES];
        logic [ehb_pkg::TSIZE_W-1:0] size;
        int unsigned                 items_sent;
        int unsigned                 phase_sent;
        int unsigned                 len;
        int unsigned                 pick;
        int unsigned                 phase;

        // zero, one, the clamp, sizes above it, alternating bit patterns
        fixed_sizes = '{17'd1, 17'd0, 17'd65536, 17'h1FFFF, 17'd65537,
                        17'd2, 17'h0AAAA, 17'h15555, 17'd1000, 17'd7};
        items_sent = 0;
        phase      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed names under the reset table size
        send_char(8'hFF, 1'b1);                 // top byte alone
        send_char(8'h00, 1'b1);                 // zero byte is hashed, not an end
        send_char(8'h01, 1'b1);
        // seven low nibbles build 0x0FFFFFFF, the last byte wraps past bit 31
        repeat (7) send_char(8'h0F, 1'b0);
        send_char(8'hFF, 1'b1);
        // long run of top bytes keeps the fold busy
        repeat (9) send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        // zero byte inside a name
        send_char(8'h41, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h42, 1'b1);
        in_valid <= 1'b0;

        // random phases, each with a new table size
        while (items_sent < RANDOM_ITEMS)
        begin
            if (phase < FIXED_PHASES)
                size = fixed_sizes[phase];
            else if ($urandom_range(0, 3) == 0)
                size = ehb_pkg::TSIZE_W'($urandom_range(0, 17'h1FFFF));
            else
                size = ehb_pkg::TSIZE_W'($urandom_range(1, 65536));
            write_table_size(size);

            if (phase == PRESSURE_PHASE)
            begin
                hold_output = 1'b1;
                tx_no_gaps  = 1'b1;
            end

            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS && items_sent + phase_sent < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (phase == PRESSURE_PHASE)
                    len = $urandom_range(1, 3);      // short names fill the job queue
                else if (pick < 14)
                    len = $urandom_range(1, 8);
                else if (pick < 19)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 64);
                send_name(len);
                phase_sent += len;
            end
            in_valid   <= 1'b0;
            tx_no_gaps  = 1'b0;
            items_sent += phase_sent;
            phase++;
        end

        // drain and let the back stage settle
        while (hash_board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (hash_board.mismatches == 0 && hash_board.pending() == 0)
            $display("elf_string_hash_bucket: match");
        else
            $display("elf_string_hash_bucket: mismatch");
        $finish;
    end

endmodule
